FILE: hw/rtl/llah_pkg.sv
// Shared types, constants, command codes and ordering function for the area heap.
package llah_pkg;

   localparam int CAP_DEFAULT  = 16;
   localparam int RESULT_LIMIT = 16;
   localparam int ID_W         = 5;
   localparam int CNT_W        = 16;
   localparam int STAMP_W      = 32;
   localparam int STATUS_W     = 3;
   localparam int NRES_W       = 5;

   localparam logic [STATUS_W-1:0] ST_CREATED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_INCR    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_KEPT    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_REMOVED = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOTHING = 3'd4;

   localparam logic KIND_ACCESS = 1'b0;
   localparam logic KIND_TRIM   = 1'b1;

   localparam int OP_W = 5;
   localparam logic [OP_W-1:0] OP_NOP       = 5'd0;
   localparam logic [OP_W-1:0] OP_LOAD      = 5'd1;
   localparam logic [OP_W-1:0] OP_NONE_RES  = 5'd2;
   localparam logic [OP_W-1:0] OP_SCAN_RD   = 5'd3;
   localparam logic [OP_W-1:0] OP_SCAN_NEXT = 5'd4;
   localparam logic [OP_W-1:0] OP_HIT       = 5'd5;
   localparam logic [OP_W-1:0] OP_PUSH_NEW  = 5'd6;
   localparam logic [OP_W-1:0] OP_SU_RD     = 5'd7;
   localparam logic [OP_W-1:0] OP_SU_MOVE   = 5'd8;
   localparam logic [OP_W-1:0] OP_SD_RDL    = 5'd9;
   localparam logic [OP_W-1:0] OP_SD_LCMP   = 5'd10;
   localparam logic [OP_W-1:0] OP_SD_RCMP   = 5'd11;
   localparam logic [OP_W-1:0] OP_SD_MOVE   = 5'd12;
   localparam logic [OP_W-1:0] OP_PUT       = 5'd13;
   localparam logic [OP_W-1:0] OP_EMIT      = 5'd14;
   localparam logic [OP_W-1:0] OP_POP_RD    = 5'd15;
   localparam logic [OP_W-1:0] OP_POP_TAKE  = 5'd16;
   localparam logic [OP_W-1:0] OP_POP_LAST  = 5'd17;
   localparam logic [OP_W-1:0] OP_KCLR      = 5'd18;
   localparam logic [OP_W-1:0] OP_RE_DROP   = 5'd19;
   localparam logic [OP_W-1:0] OP_RE_PUSH   = 5'd20;

   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [CNT_W-1:0]   cnt;
      logic [STAMP_W-1:0] stamp;
   } entry_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
   } cmd_type;

   typedef struct packed {
      logic kind;
      logic id_bad;
      logic n_zero;
      logic scan_end;
      logic hit;
      logic full;
      logic pos_zero;
      logic cur_before_rd;
      logic lc_in;
      logic rc_in;
      logic best_at_pos;
      logic k_done;
      logic last_one;
      logic trim_drop;
      logic rsp_free;
   } stat_type;

   function automatic logic goes_before(entry_type a, entry_type b);
      if (a.cnt != b.cnt) return a.cnt < b.cnt;
      return a.stamp < b.stamp;
   endfunction

endpackage

FILE: hw/rtl/llah_ctrl.sv
// Sequencer for lookup, sift, pop and reinsert steps of the area heap.
module llah_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  llah_pkg::stat_type stat,
   output llah_pkg::cmd_type  cmd
);
   import llah_pkg::*;

   localparam logic [4:0] S_IDLE     = 5'd0;
   localparam logic [4:0] S_DISP     = 5'd1;
   localparam logic [4:0] S_NONE     = 5'd2;
   localparam logic [4:0] S_SCAN     = 5'd3;
   localparam logic [4:0] S_SCAN_CMP = 5'd4;
   localparam logic [4:0] S_SU       = 5'd5;
   localparam logic [4:0] S_SU_CMP   = 5'd6;
   localparam logic [4:0] S_SD_L     = 5'd7;
   localparam logic [4:0] S_SD_LCMP  = 5'd8;
   localparam logic [4:0] S_SD_RCMP  = 5'd9;
   localparam logic [4:0] S_SD_DEC   = 5'd10;
   localparam logic [4:0] S_PUT      = 5'd11;
   localparam logic [4:0] S_EMIT     = 5'd12;
   localparam logic [4:0] S_EMIT_CHK = 5'd13;
   localparam logic [4:0] S_POP_CHK  = 5'd14;
   localparam logic [4:0] S_POP_TAKE = 5'd15;
   localparam logic [4:0] S_POP_LAST = 5'd16;
   localparam logic [4:0] S_RE       = 5'd17;

   localparam logic [1:0] PH_ACC   = 2'd0;
   localparam logic [1:0] PH_POP   = 2'd1;
   localparam logic [1:0] PH_REINS = 2'd2;

   logic [4:0] state_ff, state_in;
   logic [1:0] phase_ff, phase_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      cmd.op   = OP_NOP;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.op   = OP_LOAD;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            if (stat.kind == KIND_ACCESS) begin
               phase_in = PH_ACC;
               state_in = stat.id_bad ? S_NONE : S_SCAN;
            end else begin
               phase_in = PH_POP;
               state_in = stat.n_zero ? S_NONE : S_POP_CHK;
            end
         end
         S_NONE: begin
            cmd.op   = OP_NONE_RES;
            phase_in = PH_ACC;
            state_in = S_EMIT;
         end
         S_SCAN: begin
            if (stat.scan_end) begin
               if (stat.full) state_in = S_NONE;
               else begin
                  cmd.op   = OP_PUSH_NEW;
                  state_in = S_SU;
               end
            end else begin
               cmd.op   = OP_SCAN_RD;
               state_in = S_SCAN_CMP;
            end
         end
         S_SCAN_CMP: begin
            if (stat.hit) begin
               cmd.op   = OP_HIT;
               state_in = S_SD_L;
            end else begin
               cmd.op   = OP_SCAN_NEXT;
               state_in = S_SCAN;
            end
         end
         S_SU: begin
            if (stat.pos_zero) state_in = S_PUT;
            else begin
               cmd.op   = OP_SU_RD;
               state_in = S_SU_CMP;
            end
         end
         S_SU_CMP: begin
            if (stat.cur_before_rd) begin
               cmd.op   = OP_SU_MOVE;
               state_in = S_SU;
            end else state_in = S_PUT;
         end
         S_SD_L: begin
            if (!stat.lc_in) state_in = S_PUT;
            else begin
               cmd.op   = OP_SD_RDL;
               state_in = S_SD_LCMP;
            end
         end
         S_SD_LCMP: begin
            cmd.op   = OP_SD_LCMP;
            state_in = stat.rc_in ? S_SD_RCMP : S_SD_DEC;
         end
         S_SD_RCMP: begin
            cmd.op   = OP_SD_RCMP;
            state_in = S_SD_DEC;
         end
         S_SD_DEC: begin
            if (stat.best_at_pos) state_in = S_PUT;
            else begin
               cmd.op   = OP_SD_MOVE;
               state_in = S_SD_L;
            end
         end
         S_PUT: begin
            cmd.op   = OP_PUT;
            state_in = (phase_ff == PH_POP) ? S_POP_CHK : S_EMIT;
         end
         S_EMIT: begin
            if (stat.rsp_free) begin
               cmd.op   = OP_EMIT;
               state_in = S_EMIT_CHK;
            end
         end
         S_EMIT_CHK: begin
            state_in = (phase_ff == PH_REINS && !stat.k_done) ? S_RE : S_IDLE;
         end
         S_POP_CHK: begin
            if (stat.k_done) begin
               cmd.op   = OP_KCLR;
               phase_in = PH_REINS;
               state_in = S_RE;
            end else begin
               cmd.op   = OP_POP_RD;
               state_in = S_POP_TAKE;
            end
         end
         S_POP_TAKE: begin
            cmd.op   = OP_POP_TAKE;
            state_in = stat.last_one ? S_POP_CHK : S_POP_LAST;
         end
         S_POP_LAST: begin
            cmd.op   = OP_POP_LAST;
            state_in = S_SD_L;
         end
         S_RE: begin
            if (stat.trim_drop) begin
               cmd.op   = OP_RE_DROP;
               state_in = S_EMIT;
            end else begin
               cmd.op   = OP_RE_PUSH;
               state_in = S_SU;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= PH_ACC;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

endmodule

FILE: hw/rtl/llah_dp.sv
// Heap memory, stamp clock, pop list and response register of the area heap.
module llah_dp #(
   parameter int CAPACITY = llah_pkg::CAP_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_kind,
   input  logic [llah_pkg::ID_W-1:0]      req_id,
   input  logic [llah_pkg::CNT_W-1:0]     req_amount,
   input  llah_pkg::cmd_type              cmd,
   output llah_pkg::stat_type             stat,
   output logic                           rsp_valid,
   input  logic                           rsp_tready,
   output logic [llah_pkg::ID_W-1:0]      rsp_area,
   output logic [llah_pkg::CNT_W-1:0]     rsp_count,
   output logic [llah_pkg::STATUS_W-1:0]  rsp_status,
   output logic                           rsp_last
);
   import llah_pkg::*;

   localparam int PW = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int KW = $clog2(RESULT_LIMIT);

   entry_type mem [CAPACITY];
   entry_type rd_ff;
   logic [PW-1:0] rd_addr;
   logic [PW-1:0] wr_addr;
   logic          wr_en;
   entry_type     wr_data;

   logic              kind_ff;
   logic [ID_W-1:0]   id_ff;
   logic [CNT_W-1:0]  amount_ff;
   logic [CW-1:0]     fill_ff, fill_in;
   logic [STAMP_W-1:0] clock_ff, clock_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic [PW-1:0]     pos_ff, pos_in;
   entry_type         cur_ff, cur_in;
   entry_type         best_ff, best_in;
   logic [PW-1:0]     best_pos_ff, best_pos_in;
   logic [NRES_W-1:0] k_ff, k_in;
   logic [NRES_W-1:0] n_ff, n_in;
   logic [ID_W-1:0]   pid_ff [RESULT_LIMIT];
   logic [CNT_W-1:0]  pcnt_ff [RESULT_LIMIT];
   logic [ID_W-1:0]   res_area_ff, res_area_in;
   logic [CNT_W-1:0]  res_count_ff, res_count_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]   rsp_area_ff;
   logic [CNT_W-1:0]  rsp_count_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic              rsp_last_ff;

   logic [PW+1:0]     lc, rc;
   logic [PW-1:0]     parent;
   logic [KW-1:0]     kx;
   logic [NRES_W-1:0] n_load;
   logic [CNT_W-1:0]  incr_cnt;

   assign lc     = {1'b0, pos_ff, 1'b1};
   assign rc     = lc + 1'b1;
   assign parent = (pos_ff - 1'b1) >> 1;
   assign kx     = k_ff[KW-1:0];
   assign incr_cnt = (rd_ff.cnt == '1) ? rd_ff.cnt : rd_ff.cnt + 1'b1;

   always_comb begin
      int a;
      int f;
      int m;
      a = int'(req_amount);
      f = int'(fill_ff);
      m = (a < f) ? a : f;
      if (m > RESULT_LIMIT) m = RESULT_LIMIT;
      n_load = NRES_W'(m);
   end

   always_comb begin
      stat.kind          = kind_ff;
      stat.id_bad        = (id_ff == '0) || (int'(id_ff) > CAPACITY);
      stat.n_zero        = (n_ff == '0);
      stat.scan_end      = (idx_ff == fill_ff);
      stat.hit           = (rd_ff.id == id_ff);
      stat.full          = (int'(fill_ff) == CAPACITY);
      stat.pos_zero      = (pos_ff == '0);
      stat.cur_before_rd = goes_before(cur_ff, rd_ff);
      stat.lc_in         = (lc < (PW+2)'(fill_ff));
      stat.rc_in         = (rc < (PW+2)'(fill_ff));
      stat.best_at_pos   = (best_pos_ff == pos_ff);
      stat.k_done        = (k_ff == n_ff);
      stat.last_one      = (fill_ff == CW'(1));
      stat.trim_drop     = (amount_ff >= pcnt_ff[kx]);
      stat.rsp_free      = !rsp_valid_ff || rsp_tready;
   end

   always_comb begin
      fill_in       = fill_ff;
      clock_in      = clock_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      cur_in        = cur_ff;
      best_in       = best_ff;
      best_pos_in   = best_pos_ff;
      k_in          = k_ff;
      n_in          = n_ff;
      res_area_in   = res_area_ff;
      res_count_in  = res_count_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rd_addr       = '0;
      wr_addr       = pos_ff;
      wr_en         = 1'b0;
      wr_data       = cur_ff;
      case (cmd.op)
         OP_LOAD: begin
            idx_in = '0;
            k_in   = '0;
            n_in   = n_load;
         end
         OP_NONE_RES: begin
            res_area_in   = '0;
            res_count_in  = '0;
            res_status_in = ST_NOTHING;
         end
         OP_SCAN_RD:   rd_addr = idx_ff[PW-1:0];
         OP_SCAN_NEXT: idx_in  = idx_ff + 1'b1;
         OP_HIT: begin
            cur_in        = '{id: id_ff, cnt: incr_cnt, stamp: clock_ff};
            clock_in      = clock_ff + 1'b1;
            pos_in        = idx_ff[PW-1:0];
            res_area_in   = id_ff;
            res_count_in  = incr_cnt;
            res_status_in = ST_INCR;
         end
         OP_PUSH_NEW: begin
            cur_in        = '{id: id_ff, cnt: CNT_W'(1), stamp: clock_ff};
            clock_in      = clock_ff + 1'b1;
            pos_in        = fill_ff[PW-1:0];
            fill_in       = fill_ff + 1'b1;
            res_area_in   = id_ff;
            res_count_in  = CNT_W'(1);
            res_status_in = ST_CREATED;
         end
         OP_SU_RD: rd_addr = parent;
         OP_SU_MOVE: begin
            wr_en   = 1'b1;
            wr_data = rd_ff;
            pos_in  = parent;
         end
         OP_SD_RDL: rd_addr = lc[PW-1:0];
         OP_SD_LCMP: begin
            rd_addr = rc[PW-1:0];
            if (goes_before(rd_ff, cur_ff)) begin
               best_in     = rd_ff;
               best_pos_in = lc[PW-1:0];
            end else begin
               best_in     = cur_ff;
               best_pos_in = pos_ff;
            end
         end
         OP_SD_RCMP: begin
            if (goes_before(rd_ff, best_ff)) begin
               best_in     = rd_ff;
               best_pos_in = rc[PW-1:0];
            end
         end
         OP_SD_MOVE: begin
            wr_en   = 1'b1;
            wr_data = best_ff;
            pos_in  = best_pos_ff;
         end
         OP_PUT: wr_en = 1'b1;
         OP_EMIT: begin
            rsp_valid_in = 1'b1;
            k_in         = k_ff + 1'b1;
         end
         OP_POP_RD: rd_addr = '0;
         OP_POP_TAKE: begin
            rd_addr = PW'(fill_ff - 1'b1);
            k_in    = k_ff + 1'b1;
            fill_in = fill_ff - 1'b1;
         end
         OP_POP_LAST: begin
            cur_in = rd_ff;
            pos_in = '0;
         end
         OP_KCLR: k_in = '0;
         OP_RE_DROP: begin
            res_area_in   = pid_ff[kx];
            res_count_in  = '0;
            res_status_in = ST_REMOVED;
         end
         OP_RE_PUSH: begin
            cur_in        = '{id: pid_ff[kx], cnt: pcnt_ff[kx] - amount_ff,
                              stamp: clock_ff};
            clock_in      = clock_ff + 1'b1;
            pos_in        = fill_ff[PW-1:0];
            fill_in       = fill_ff + 1'b1;
            res_area_in   = pid_ff[kx];
            res_count_in  = pcnt_ff[kx] - amount_ff;
            res_status_in = ST_KEPT;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         clock_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         clock_ff     <= clock_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD) begin
         kind_ff   <= req_kind;
         id_ff     <= req_id;
         amount_ff <= req_amount;
      end
      if (cmd.op == OP_POP_TAKE) begin
         pid_ff[kx]  <= rd_ff.id;
         pcnt_ff[kx] <= rd_ff.cnt;
      end
      if (cmd.op == OP_EMIT) begin
         rsp_area_ff   <= res_area_ff;
         rsp_count_ff  <= res_count_ff;
         rsp_status_ff <= res_status_ff;
         rsp_last_ff   <= !(kind_ff == KIND_TRIM && n_ff != '0) || (k_ff + 1'b1 == n_ff);
      end
      idx_ff        <= idx_in;
      pos_ff        <= pos_in;
      cur_ff        <= cur_in;
      best_ff       <= best_in;
      best_pos_ff   <= best_pos_in;
      k_ff          <= k_in;
      n_ff          <= n_in;
      res_area_ff   <= res_area_in;
      res_count_ff  <= res_count_in;
      res_status_ff <= res_status_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_area   = rsp_area_ff;
   assign rsp_count  = rsp_count_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

FILE: hw/rtl/lfu_lru_area_heap.sv
// Top level of the least-used area heap with oldest-first tie break.
//
//  channel | direction | tdata fields (low bit up)                  | tuser | tlast
//  req_    | in        | area_id[4:0], trim_amount[20:5], zero pad  | kind  | -
//  rsp_    | out       | result_area[4:0], result_count[20:5],      | -     | last
//          |           | status[23:21]                              |       |
//
//  One request at a time: the block accepts and dispatches it, then emits each result.
//  An access searches the stored areas in turn, then sifts down on a hit or sifts up on
//  a create, and writes the area back.
//  A trim pops each area with a sift-down and a write-back, then per result decides and,
//  for a kept area, sifts it up and writes it back.
//  Synchronous reset empties the heap and zeroes the stamp clock; no clearing pass. A
//  result waits in the output register while rsp_tready is low; the sequencer holds.
module lfu_lru_area_heap #(
   parameter int CAPACITY = llah_pkg::CAP_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // area_id[4:0], trim_amount[20:5], pad
   input  logic        req_tuser,   // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // result_area[4:0], result_count[20:5], status[23:21]
   output logic        rsp_tlast
);
   import llah_pkg::*;

   cmd_type  cmd;
   stat_type stat;
   logic [ID_W-1:0]     rsp_area;
   logic [CNT_W-1:0]    rsp_count;
   logic [STATUS_W-1:0] rsp_status;

   llah_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // Heap storage and all arithmetic; the sequencer drives one command per cycle.
   llah_dp #(.CAPACITY(CAPACITY)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_kind   (req_tuser),
      .req_id     (req_tdata[4:0]),
      .req_amount (req_tdata[20:5]),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_valid  (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_area   (rsp_area),
      .rsp_count  (rsp_count),
      .rsp_status (rsp_status),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {rsp_status, rsp_count, rsp_area};

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the least-used area heap: directed and random requests.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import llah_pkg::*;

   localparam int CAP       = 16;
   localparam int CYC_LIMIT = 1500000;

   typedef struct packed {
      logic [ID_W-1:0]     area;
      logic [CNT_W-1:0]    count;
      logic [STATUS_W-1:0] status;
      logic                last;
   } outcome_type;

   // Scoreboard: holds its own copy of the heap and queues predicted outcomes.
   class area_heap_board;
      logic [ID_W-1:0]    ids[CAP];
      logic [CNT_W-1:0]   cnts[CAP];
      logic [STAMP_W-1:0] stamps[CAP];
      int                 fill;
      logic [STAMP_W-1:0] clk_stamp;
      outcome_type        pending[$];
      int                 errors;
      int                 checked;

      function new();
         fill = 0;
         clk_stamp = '0;
         errors = 0;
         checked = 0;
      endfunction

      function bit ahead(int a, int b);
         if (cnts[a] != cnts[b]) return cnts[a] < cnts[b];
         return stamps[a] < stamps[b];
      endfunction

      function void swap(int a, int b);
         logic [ID_W-1:0]    i;
         logic [CNT_W-1:0]   c;
         logic [STAMP_W-1:0] s;
         i = ids[a]; c = cnts[a]; s = stamps[a];
         ids[a] = ids[b]; cnts[a] = cnts[b]; stamps[a] = stamps[b];
         ids[b] = i; cnts[b] = c; stamps[b] = s;
      endfunction

      function void bubble_up(int p);
         while (p > 0 && ahead(p, (p - 1) / 2)) begin
            swap(p, (p - 1) / 2);
            p = (p - 1) / 2;
         end
      endfunction

      function void bubble_down(int p);
         int l;
         int best;
         while (p < fill) begin
            l = 2 * p + 1;
            best = p;
            if (l < fill && ahead(l, best)) best = l;
            if (l + 1 < fill && ahead(l + 1, best)) best = l + 1;
            if (best == p) break;
            swap(p, best);
            p = best;
         end
      endfunction

      function void insert(logic [ID_W-1:0] id, logic [CNT_W-1:0] c);
         ids[fill] = id;
         cnts[fill] = c;
         stamps[fill] = clk_stamp;
         clk_stamp++;
         fill++;
         bubble_up(fill - 1);
      endfunction

      function void emit(logic [ID_W-1:0] a, logic [CNT_W-1:0] c, logic [STATUS_W-1:0] s,
                         logic l);
         outcome_type o;
         o.area = a; o.count = c; o.status = s; o.last = l;
         pending = {pending, o};
      endfunction

      // Note one accepted request and queue what it must produce.
      function void note_request(logic kind, logic [ID_W-1:0] id, logic [CNT_W-1:0] amt);
         logic [ID_W-1:0]  pid[RESULT_LIMIT];
         logic [CNT_W-1:0] pcnt[RESULT_LIMIT];
         int n;
         if (kind == KIND_ACCESS) begin
            if (id == 0 || id > CAP) begin
               emit('0, '0, ST_NOTHING, 1'b1);
               return;
            end
            for (int i = 0; i < fill; i++) begin
               if (ids[i] == id) begin
                  if (cnts[i] != '1) cnts[i]++;
                  stamps[i] = clk_stamp;
                  clk_stamp++;
                  emit(id, cnts[i], ST_INCR, 1'b1);
                  bubble_down(i);
                  return;
               end
            end
            if (fill >= CAP) begin
               emit('0, '0, ST_NOTHING, 1'b1);
               return;
            end
            insert(id, 16'd1);
            emit(id, 16'd1, ST_CREATED, 1'b1);
         end else begin
            n = (amt < fill) ? amt : fill;
            if (n > RESULT_LIMIT) n = RESULT_LIMIT;
            if (n == 0) begin
               emit('0, '0, ST_NOTHING, 1'b1);
               return;
            end
            for (int k = 0; k < n; k++) begin
               pid[k] = ids[0];
               pcnt[k] = cnts[0];
               ids[0] = ids[fill - 1];
               cnts[0] = cnts[fill - 1];
               stamps[0] = stamps[fill - 1];
               fill--;
               bubble_down(0);
            end
            for (int k = 0; k < n; k++) begin
               if (amt >= pcnt[k]) emit(pid[k], '0, ST_REMOVED, k + 1 == n);
               else begin
                  insert(pid[k], pcnt[k] - amt);
                  emit(pid[k], pcnt[k] - amt, ST_KEPT, k + 1 == n);
               end
            end
         end
      endfunction

      // Compare one accepted result against the oldest prediction.
      function void check_result(outcome_type got);
         outcome_type want;
         checked++;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected result area=%0d count=%0d status=%0d last=%0d",
                        got.area, got.count, got.status, got.last);
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: want area=%0d count=%0d st=%0d last=%0d, got %0d %0d %0d %0d",
                        want.area, want.count, want.status, want.last,
                        got.area, got.count, got.status, got.last);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // area_id[4:0], trim_amount[20:5], pad
   logic        req_tuser = 1'b0; // kind
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // result_area[4:0], result_count[20:5], status[23:21]
   logic        rsp_tlast;

   area_heap_board board = new();
   int  cycles = 0;
   int  sent = 0;
   bit  hold_rsp = 1'b0;   // long receiver hold-off requested by the stimulus
   int  trims = 0;

   always #1 clock = ~clock;

   lfu_lru_area_heap #(.CAPACITY(CAP)) uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
   );

   // Watchdog: count cycles and stop a hung run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYC_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("FAIL");
         $finish;
      end
   end

   // Sample the result channel; the handshake is decided on the values before the edge.
   always @(posedge clock) begin
      outcome_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.area = rsp_tdata[4:0];
         got.count = rsp_tdata[20:5];
         got.status = rsp_tdata[23:21];
         got.last = rsp_tlast;
         board.check_result(got);
      end
   end

   // Receiver: draw a stall for each result, hold off while asked.
   initial begin
      int gap;
      @(posedge clock iff !reset);
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            @(posedge clock);
         end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
            if (gap > 0) begin
               rsp_tready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            rsp_tready <= 1'b1;
            @(posedge clock iff (rsp_tvalid && rsp_tready) || hold_rsp);
         end
      end
   end

   // Offer one request and wait for the block to take it.
   task automatic send_request(logic kind, logic [4:0] id, logic [15:0] amt, bit idle_ok);
      int gap;
      gap = idle_ok ? ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 18)) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {3'b000, amt, id};
      @(posedge clock iff req_tready);
      board.note_request(kind, id, amt);
      if (kind == KIND_TRIM) trims++;
      sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock iff board.pending.size() == 0);
   endtask

   // One random request: mostly valid accesses, some trims, some junk.
   task automatic random_request(bit idle_ok);
      int pick;
      logic [15:0] amt;
      pick = $urandom_range(0, 99);
      if (pick < 72)
         send_request(KIND_ACCESS, 5'($urandom_range(1, CAP)), 16'($urandom), idle_ok);
      else if (pick < 78)
         send_request(KIND_ACCESS, ($urandom_range(0, 1) ? 5'd0 : 5'($urandom_range(17, 31))),
                      16'($urandom), idle_ok);
      else begin
         case ($urandom_range(0, 3))
            0: amt = 16'($urandom_range(0, 3));
            1: amt = 16'($urandom_range(1, 20));
            2: amt = 16'($urandom);
            default: amt = 16'($urandom_range(2, 8));
         endcase
         send_request(KIND_TRIM, 5'($urandom), amt, idle_ok);
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty trim, bad ids, fill to capacity, repeats and trims.
      send_request(KIND_TRIM, 5'd3, 16'd5, 1'b0);
      send_request(KIND_ACCESS, 5'd0, 16'hFFFF, 1'b0);
      send_request(KIND_ACCESS, 5'd31, 16'h0000, 1'b0);
      send_request(KIND_ACCESS, 5'd17, 16'h5555, 1'b0);
      for (int i = 1; i <= CAP; i++)
         send_request(KIND_ACCESS, 5'(i), 16'hAAAA, 1'b0);
      send_request(KIND_ACCESS, 5'd16, 16'd0, 1'b0);
      send_request(KIND_ACCESS, 5'd1, 16'd0, 1'b0);
      send_request(KIND_TRIM, 5'd0, 16'd0, 1'b0);
      send_request(KIND_TRIM, 5'd31, 16'd1, 1'b0);
      send_request(KIND_TRIM, 5'd0, 16'hFFFF, 1'b0);
      drain();

      // Random with idling on both sides.
      repeat (150) random_request(1'b1);

      // Receiver holds off while the sender keeps offering back to back.
      hold_rsp = 1'b1;
      fork
         repeat (400) @(posedge clock);
         repeat (20) random_request(1'b0);
      join_any
      hold_rsp = 1'b0;
      wait fork;

      // Sender pauses until every result has arrived.
      drain();
      repeat (190) random_request($urandom_range(0, 3) != 0);
      drain();

      repeat (300) @(posedge clock);
      $display("run covered %0d requests (%0d trims) and %0d results", sent, trims,
               board.checked);
      $display("heap held %0d areas at the end, %0d errors", board.fill, board.errors);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end
endmodule
